// File: design/gmo_pkg.sv
// shared types, constants and the arc-cosine table of the gradient magnitude block
package gmo_pkg;

	localparam int CHANNELS_DEF = 3;
	localparam int GW = 16;
	localparam int SUM_W = 32;
	localparam int ROOT_W = 16;
	localparam int QUO_W = 10;
	localparam int NUM_W = 26;
	localparam int ROM_SIZE = 2001;
	localparam int ROM_HALF = 1000;
	localparam int IDX_W = $clog2(ROM_SIZE);
	localparam int ANG_MAX = 51472;

	// side data that rides along with each pixel through the cells
	typedef struct packed {
		logic            vld;
		logic [GW-1:0]   ax;
		logic            pos;
		logic            fe;
	} side_t;

	typedef logic [15:0] rom_t [ROM_SIZE];

	function automatic rom_t build_rom();
		rom_t r;
		real x;
		for (int e = 0; e < ROM_SIZE; e++) begin
			x = real'(e - ROM_HALF) / 1000.0;
			r[e] = 16'($rtoi($acos(x) * 16384.0 + 0.5));
		end
		return r;
	endfunction

	localparam rom_t ACOS_ROM = build_rom();

endpackage

// File: design/gmo_sqrt_cell.sv
// one bit of the restoring square root chain
module gmo_sqrt_cell #(
	parameter int BIT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gmo_pkg::SUM_W-1:0]   rem_in,
	input  logic [gmo_pkg::ROOT_W-1:0]  root_in,
	input  gmo_pkg::side_t              side_in,
	output logic [gmo_pkg::SUM_W-1:0]   rem_out,
	output logic [gmo_pkg::ROOT_W-1:0]  root_out,
	output gmo_pkg::side_t              side_out
);

	logic [gmo_pkg::SUM_W+1:0] trial;
	logic [gmo_pkg::SUM_W+1:0] rem_ext;
	logic                      take;

	always_comb begin
		// (root + 2^b)^2 - root^2 = root*2^(b+1) + 2^(2b)
		trial = ((gmo_pkg::SUM_W+2)'(root_in) << (BIT + 1))
			+ ((gmo_pkg::SUM_W+2)'(1) << (2 * BIT));
		rem_ext = (gmo_pkg::SUM_W+2)'(rem_in);
		take = rem_ext >= trial;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out.vld <= 1'b0;
		end else begin
			side_out <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rem_out  <= gmo_pkg::SUM_W'(rem_ext - trial);
			root_out <= root_in | (gmo_pkg::ROOT_W'(1) << BIT);
		end else begin
			rem_out  <= rem_in;
			root_out <= root_in;
		end
	end

endmodule

// File: design/gmo_div_cell.sv
// one quotient bit of the restoring divider chain
module gmo_div_cell #(
	parameter int BIT = 0
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [gmo_pkg::NUM_W-1:0]   num_in,
	input  logic [gmo_pkg::ROOT_W-1:0]  den_in,
	input  logic [gmo_pkg::QUO_W-1:0]   quo_in,
	input  gmo_pkg::side_t              side_in,
	output logic [gmo_pkg::NUM_W-1:0]   num_out,
	output logic [gmo_pkg::ROOT_W-1:0]  den_out,
	output logic [gmo_pkg::QUO_W-1:0]   quo_out,
	output gmo_pkg::side_t              side_out
);

	logic [gmo_pkg::NUM_W-1:0] shifted;
	logic                      take;

	always_comb begin
		shifted = gmo_pkg::NUM_W'(den_in) << BIT;
		take = num_in >= shifted;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_out.vld <= 1'b0;
		end else begin
			side_out <= side_in;
		end
	end

	always_ff @(posedge clk) begin
		den_out <= den_in;
		if (take) begin
			num_out <= num_in - shifted;
			quo_out <= quo_in | (gmo_pkg::QUO_W'(1) << BIT);
		end else begin
			num_out <= num_in;
			quo_out <= quo_in;
		end
	end

endmodule

// File: design/gradient_magnitude_orientation_top.sv
// gradient magnitude and unsigned orientation, top level with square root and divider chains
//
// channel   ports                                   transaction
// input     start, busy, gx_ch*, gy_ch*, frame_end  start high while busy low
// result    done, magnitude, orientation,           done high for one cycle
//           frame_end_out
//
// one pixel accepted every cycle, busy is always low
// each result passes through squares, channel pick,
// 16 square root cells, scaling, 10 divider cells and the table read
// reset clears only the valid bits of the chain
// the receiver cannot stall, so nothing in the chain ever waits
module gradient_magnitude_orientation_top #(
	parameter int CHANNELS = gmo_pkg::CHANNELS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic signed [15:0]       gx_ch0,
	input  logic signed [15:0]       gy_ch0,
	input  logic signed [15:0]       gx_ch1,
	input  logic signed [15:0]       gy_ch1,
	input  logic signed [15:0]       gx_ch2,
	input  logic signed [15:0]       gy_ch2,
	input  logic                     frame_end,
	output logic                     done,
	output logic [15:0]              magnitude,
	output logic [15:0]              orientation,
	output logic                     frame_end_out
);

	localparam int SQ = gmo_pkg::ROOT_W;
	localparam int DQ = gmo_pkg::QUO_W;
	localparam int LAT = 4 + SQ + DQ;

	assign busy = 1'b0;

	// stage 1: squares per channel
	logic [gmo_pkg::SUM_W-1:0] sum_s1 [3];
	logic signed [15:0]        gx_s1 [3];
	logic signed [15:0]        gy_s1 [3];
	logic                      vld_s1, fe_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		fe_s1 <= frame_end;
		gx_s1[0] <= gx_ch0;
		gy_s1[0] <= gy_ch0;
		gx_s1[1] <= gx_ch1;
		gy_s1[1] <= gy_ch1;
		gx_s1[2] <= gx_ch2;
		gy_s1[2] <= gy_ch2;
		sum_s1[0] <= gmo_pkg::SUM_W'(gx_ch0 * gx_ch0) + gmo_pkg::SUM_W'(gy_ch0 * gy_ch0);
		sum_s1[1] <= gmo_pkg::SUM_W'(gx_ch1 * gx_ch1) + gmo_pkg::SUM_W'(gy_ch1 * gy_ch1);
		sum_s1[2] <= gmo_pkg::SUM_W'(gx_ch2 * gx_ch2) + gmo_pkg::SUM_W'(gy_ch2 * gy_ch2);
	end

	// stage 2: pick the strongest channel, lowest wins a tie
	logic [gmo_pkg::SUM_W-1:0] best;
	logic signed [15:0]        bgx, bgy;
	logic [gmo_pkg::SUM_W-1:0] sum_s2;
	gmo_pkg::side_t            side_s2;

	always_comb begin
		best = sum_s1[0];
		bgx = gx_s1[0];
		bgy = gy_s1[0];
		for (int c = 1; c < 3; c++) begin
			if (c < CHANNELS && sum_s1[c] > best) begin
				best = sum_s1[c];
				bgx = gx_s1[c];
				bgy = gy_s1[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s2.vld <= 1'b0;
		end else begin
			side_s2.vld <= vld_s1;
			side_s2.fe <= fe_s1;
			side_s2.ax <= bgx[15] ? 16'(-bgx) : 16'(bgx);
			side_s2.pos <= (bgx > 16'sd0 && bgy > 16'sd0) || (bgx < 16'sd0 && bgy <= 16'sd0);
		end
	end

	always_ff @(posedge clk) begin
		sum_s2 <= best;
	end

	// square root chain, msb first
	logic [gmo_pkg::SUM_W-1:0]  rem_c  [SQ+1];
	logic [gmo_pkg::ROOT_W-1:0] root_c [SQ+1];
	gmo_pkg::side_t             sside_c [SQ+1];

	assign rem_c[0] = sum_s2;
	assign root_c[0] = '0;
	assign sside_c[0] = side_s2;

	for (genvar k = 0; k < SQ; k++) begin : g_sqrt
		gmo_sqrt_cell #(.BIT(SQ - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.rem_in   (rem_c[k]),
			.root_in  (root_c[k]),
			.side_in  (sside_c[k]),
			.rem_out  (rem_c[k+1]),
			.root_out (root_c[k+1]),
			.side_out (sside_c[k+1])
		);
	end

	// scaling stage: magnitude floor of one, numerator ax*1000
	logic [gmo_pkg::ROOT_W-1:0] mag_s3;
	logic [gmo_pkg::NUM_W-1:0]  num_s3;
	gmo_pkg::side_t             side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s3.vld <= 1'b0;
		end else begin
			side_s3 <= sside_c[SQ];
		end
	end

	always_ff @(posedge clk) begin
		mag_s3 <= (root_c[SQ] == '0) ? gmo_pkg::ROOT_W'(1) : root_c[SQ];
		num_s3 <= gmo_pkg::NUM_W'(sside_c[SQ].ax) * gmo_pkg::NUM_W'(1000);
	end

	// divider chain, quotient never exceeds 1000 since |gx| <= magnitude
	logic [gmo_pkg::NUM_W-1:0]  num_c  [DQ+1];
	logic [gmo_pkg::ROOT_W-1:0] den_c  [DQ+1];
	logic [gmo_pkg::QUO_W-1:0]  quo_c  [DQ+1];
	gmo_pkg::side_t             dside_c [DQ+1];

	assign num_c[0] = num_s3;
	assign den_c[0] = mag_s3;
	assign quo_c[0] = '0;
	assign dside_c[0] = side_s3;

	for (genvar k = 0; k < DQ; k++) begin : g_div
		gmo_div_cell #(.BIT(DQ - 1 - k)) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.num_in   (num_c[k]),
			.den_in   (den_c[k]),
			.quo_in   (quo_c[k]),
			.side_in  (dside_c[k]),
			.num_out  (num_c[k+1]),
			.den_out  (den_c[k+1]),
			.quo_out  (quo_c[k+1]),
			.side_out (dside_c[k+1])
		);
	end

	// table read into the result registers
	logic [gmo_pkg::IDX_W-1:0] idx;

	always_comb begin
		if (dside_c[DQ].pos) begin
			idx = gmo_pkg::IDX_W'(gmo_pkg::ROM_HALF) + gmo_pkg::IDX_W'(quo_c[DQ]);
		end else begin
			idx = gmo_pkg::IDX_W'(gmo_pkg::ROM_HALF) - gmo_pkg::IDX_W'(quo_c[DQ]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dside_c[DQ].vld;
		end
	end

	always_ff @(posedge clk) begin
		magnitude <= den_c[DQ];
		orientation <= gmo_pkg::ACOS_ROM[idx];
		frame_end_out <= dside_c[DQ].fe;
	end

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LAT done)
		else $error("result missing after pixel accept");

	a_mag_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (magnitude != 16'd0))
		else $error("zero magnitude");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (orientation <= 16'(gmo_pkg::ANG_MAX)))
		else $error("orientation out of range");

	a_quo_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dside_c[DQ].vld |-> (quo_c[DQ] <= 10'd1000))
		else $error("cosine index above one");

endmodule
